// ===== design/tcsw_pkg.sv =====
// Shared constants, types and command format of the text console writer.
`timescale 1ns / 1ps
package tcsw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int ESC_BUF_LEN   = 32;
    localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int LAST_ROW      = CELLS - SCREEN_WIDTH;

    localparam int CELL_W    = 11;
    localparam int DATA_W    = 16;
    localparam int COL_W     = $clog2(SCREEN_WIDTH);
    localparam int ESC_CNT_W = $clog2(ESC_BUF_LEN + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0700;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_REJ   = 2'd3;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_WRITE,
        OP_READ,
        OP_REJECT
    } t_op;

    typedef enum logic [3:0] {
        CLS_NL,
        CLS_CR,
        CLS_BS,
        CLS_ESC,
        CLS_LBR,
        CLS_M,
        CLS_DIGIT,
        CLS_SEMI,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_op               op;
        t_cls              cls;
        logic [DATA_W-1:0] data;
        logic [CELL_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CELL_W-1:0] addr;
        logic [DATA_W-1:0] val;
        logic [CELL_W-1:0] cursor;
        logic [7:0]        attr;
        logic              scrolled;
        logic              esc_active;
    } t_res;

endpackage

// ===== design/tcsw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/tcsw_front.sv =====
// Front end: classify an incoming beat into a command for the queue.
`timescale 1ns / 1ps
module tcsw_front import tcsw_pkg::*; (
    input  logic [1:0]        i_mode,
    input  logic [DATA_W-1:0] i_data,
    input  logic [CELL_W-1:0] i_cell_index,
    input  logic              i_size_is_two,
    output t_cmd              o_cmd
);
    logic [7:0] w_c;
    logic       w_in_range;

    assign w_c        = i_data[7:0];
    assign w_in_range = i_cell_index < CELL_W'(CELLS);

    always_comb begin
        o_cmd.data = i_data;
        o_cmd.idx  = i_cell_index;
        unique case (i_mode)
            MODE_BYTE:  o_cmd.op = OP_BYTE;
            MODE_WRITE: o_cmd.op = (w_in_range && i_size_is_two) ? OP_WRITE : OP_REJECT;
            MODE_READ:  o_cmd.op = w_in_range ? OP_READ : OP_REJECT;
            default:    o_cmd.op = OP_REJECT;
        endcase
        unique case (w_c) inside
            8'h0A:          o_cmd.cls = CLS_NL;
            8'h0D:          o_cmd.cls = CLS_CR;
            8'h08:          o_cmd.cls = CLS_BS;
            8'h1B:          o_cmd.cls = CLS_ESC;
            8'h5B:          o_cmd.cls = CLS_LBR;
            8'h6D:          o_cmd.cls = CLS_M;
            [8'h30:8'h39]:  o_cmd.cls = CLS_DIGIT;
            8'h3B:          o_cmd.cls = CLS_SEMI;
            default:        o_cmd.cls = CLS_OTHER;
        endcase
    end
endmodule

// ===== design/tcsw_queue.sv =====
// Short command queue between front end and back end.
`timescale 1ns / 1ps
module tcsw_queue import tcsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);
    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic                w_push, w_pop;

    assign o_full  = r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_slot[r_wp] <= i_cmd;
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== design/tcsw_back.sv =====
// Back end: cursor, attribute, SGR parsing, screen memory, scroll and clear passes.
`timescale 1ns / 1ps
module tcsw_back import tcsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);
    typedef enum logic [1:0] {
        S_BLANK,
        S_IDLE,
        S_RDWAIT,
        S_SCROLL
    } t_state;

    function automatic logic [2:0] bgr_rgb(input logic [7:0] x);
        return {x[0], x[1], x[2]};
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] r;
        r = a;
        case (c) inside
            8'd0:           r = ATTR_RESET;
            8'd5:           r = a | 8'h80;
            8'd25:          r = a & 8'h7F;
            8'd7, 8'd27:    r = {a[7], a[2:0], 1'b0, a[6:4]};
            [8'd30:8'd37]:  r = {a[7:4], 1'b0, bgr_rgb(c - 8'd30)};
            8'd39:          r = {a[7:4], 4'h7};
            [8'd40:8'd47]:  r = {a[7], bgr_rgb(c - 8'd40), a[3:0]};
            8'd49:          r = a & 8'h8F;
            [8'd90:8'd97]:  r = {a[7:4], 1'b1, bgr_rgb(c - 8'd90)};
            default:        r = a;
        endcase
        return r;
    endfunction

    t_state                r_state, n_state;
    logic [CELL_W-1:0]     r_ptr, n_ptr;
    logic                  r_blank_out, n_blank_out;
    logic                  r_pend, n_pend;
    logic [CELL_W-1:0]     r_wa, n_wa;
    logic [CELL_W-1:0]     r_cursor, n_cursor;
    logic [COL_W-1:0]      r_col, n_col;
    logic [7:0]            r_attr, n_attr;
    logic [7:0]            r_pattr, n_pattr;
    logic [ESC_CNT_W-1:0]  r_esc_cnt, n_esc_cnt;
    logic [7:0]            r_sval, n_sval;
    logic                  r_have, n_have;
    logic                  r_res_valid, n_res_valid;
    logic [1:0]            r_kind, n_kind;
    logic [CELL_W-1:0]     r_addr, n_addr;
    logic [DATA_W-1:0]     r_val, n_val;
    logic                  r_scr, n_scr;

    logic                  w_we;
    logic [CELL_W-1:0]     w_waddr, w_raddr;
    logic [DATA_W-1:0]     w_wdata, w_rdata;
    logic [CELL_W-1:0]     w_cur;
    logic [COL_W-1:0]      w_col;
    logic [11:0]           w_acc;
    logic                  w_add;
    logic [ESC_CNT_W-1:0]  w_cnt_inc;

    tcsw_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_acc = {1'b0, r_sval, 3'b0} + {3'b0, r_sval, 1'b0} + {8'b0, i_cmd.data[3:0]};
    assign w_cnt_inc = r_esc_cnt + 1'b1;
    assign w_add = ((r_esc_cnt == ESC_CNT_W'(1)) && (i_cmd.cls == CLS_LBR))
                || ((r_esc_cnt >= ESC_CNT_W'(2)) && (i_cmd.cls == CLS_M
                    || i_cmd.cls == CLS_DIGIT || i_cmd.cls == CLS_SEMI));

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_blank_out = r_blank_out;
        n_pend      = r_pend;
        n_wa        = r_wa;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_attr      = r_attr;
        n_pattr     = r_pattr;
        n_esc_cnt   = r_esc_cnt;
        n_sval      = r_sval;
        n_have      = r_have;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_val       = r_val;
        n_scr       = r_scr;
        n_res_valid = r_res_valid && !i_res_ready;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = BLANK_CELL;
        w_raddr     = i_cmd.idx;
        w_cur       = r_cursor;
        w_col       = r_col;
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            S_BLANK: begin
                w_we = 1'b1;
                if (r_ptr == CELL_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    if (r_blank_out) begin
                        n_res_valid = 1'b1;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SCROLL: begin
                w_raddr = r_ptr + CELL_W'(SCREEN_WIDTH);
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_wa;
                    w_wdata = w_rdata;
                end
                n_pend = r_ptr < CELL_W'(LAST_ROW);
                n_wa   = r_ptr;
                if (r_ptr == CELL_W'(LAST_ROW)) begin
                    n_state     = S_BLANK;
                    n_blank_out = 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_RDWAIT: begin
                n_val       = w_rdata;
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind = KIND_NONE;
                    n_addr = '0;
                    n_val  = '0;
                    n_scr  = 1'b0;
                    n_res_valid = 1'b1;
                    unique case (i_cmd.op)
                        OP_REJECT: n_kind = KIND_REJ;
                        OP_WRITE: begin
                            w_we    = 1'b1;
                            w_waddr = i_cmd.idx;
                            w_wdata = i_cmd.data;
                            n_kind  = KIND_WRITE;
                            n_addr  = i_cmd.idx;
                            n_val   = i_cmd.data;
                        end
                        OP_READ: begin
                            n_kind      = KIND_READ;
                            n_addr      = i_cmd.idx;
                            n_res_valid = 1'b0;
                            n_state     = S_RDWAIT;
                        end
                        default: begin
                            if (r_esc_cnt != '0) begin
                                if (w_add) begin
                                    n_esc_cnt = w_cnt_inc;
                                    if (i_cmd.cls == CLS_DIGIT) begin
                                        n_sval = (w_acc > 12'd255) ? 8'd255 : w_acc[7:0];
                                        n_have = 1'b1;
                                    end else if (i_cmd.cls == CLS_SEMI) begin
                                        if (r_have) begin
                                            n_pattr = sgr_apply(r_pattr, r_sval);
                                        end
                                        n_have = 1'b0;
                                        n_sval = '0;
                                    end
                                    if (i_cmd.cls == CLS_M) begin
                                        n_attr    = r_have ? sgr_apply(r_pattr, r_sval)
                                                           : r_pattr;
                                        n_esc_cnt = '0;
                                    end else if (w_cnt_inc >= ESC_CNT_W'(ESC_BUF_LEN)) begin
                                        n_esc_cnt = '0;
                                    end
                                end else begin
                                    n_esc_cnt = '0;
                                end
                            end else begin
                                unique case (i_cmd.cls)
                                    CLS_NL: begin
                                        w_cur = r_cursor + CELL_W'(SCREEN_WIDTH)
                                              - CELL_W'(r_col);
                                        w_col = '0;
                                    end
                                    CLS_CR: begin
                                        w_cur = r_cursor - CELL_W'(r_col);
                                        w_col = '0;
                                    end
                                    CLS_ESC: begin
                                        n_esc_cnt = ESC_CNT_W'(1);
                                        n_pattr   = r_attr;
                                        n_sval    = '0;
                                        n_have    = 1'b0;
                                    end
                                    CLS_BS: begin
                                        if (r_cursor != '0) begin
                                            w_cur = r_cursor - 1'b1;
                                            w_col = (r_col == '0)
                                                  ? COL_W'(SCREEN_WIDTH - 1) : r_col - 1'b1;
                                        end
                                        w_we    = 1'b1;
                                        w_waddr = w_cur;
                                        w_wdata = {r_attr, 8'h20};
                                        n_kind  = KIND_WRITE;
                                        n_addr  = w_cur;
                                        n_val   = {r_attr, 8'h20};
                                    end
                                    default: begin
                                        w_we    = 1'b1;
                                        w_waddr = r_cursor;
                                        w_wdata = {r_attr, i_cmd.data[7:0]};
                                        n_kind  = KIND_WRITE;
                                        n_addr  = r_cursor;
                                        n_val   = {r_attr, i_cmd.data[7:0]};
                                        w_cur   = r_cursor + 1'b1;
                                        w_col   = (r_col == COL_W'(SCREEN_WIDTH - 1))
                                                ? '0 : r_col + 1'b1;
                                    end
                                endcase
                                n_cursor = w_cur;
                                n_col    = w_col;
                                if (w_cur >= CELL_W'(CELLS)) begin
                                    n_cursor    = CELL_W'(LAST_ROW);
                                    n_col       = '0;
                                    n_scr       = 1'b1;
                                    n_ptr       = '0;
                                    n_pend      = 1'b0;
                                    n_res_valid = 1'b0;
                                    n_state     = S_SCROLL;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BLANK;
            r_ptr       <= '0;
            r_blank_out <= 1'b0;
            r_pend      <= 1'b0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_attr      <= ATTR_RESET;
            r_esc_cnt   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_blank_out <= n_blank_out;
            r_pend      <= n_pend;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_attr      <= n_attr;
            r_esc_cnt   <= n_esc_cnt;
            r_res_valid <= n_res_valid;
        end
        r_wa    <= n_wa;
        r_pattr <= n_pattr;
        r_sval  <= n_sval;
        r_have  <= n_have;
        r_kind  <= n_kind;
        r_addr  <= n_addr;
        r_val   <= n_val;
        r_scr   <= n_scr;
    end

    assign o_res_valid      = r_res_valid;
    assign o_res.kind       = r_kind;
    assign o_res.addr       = r_addr;
    assign o_res.val        = r_val;
    assign o_res.cursor     = r_cursor;
    assign o_res.attr       = r_attr;
    assign o_res.scrolled   = r_scr;
    assign o_res.esc_active = r_esc_cnt != '0;
endmodule

// ===== design/text_console_sgr_writer.sv =====
// Top level of the text console writer with SGR attribute handling.
//
// Input stream (s_axis): one beat per item. tuser carries the mode
// (console byte, direct cell write, cell read); tdata carries the byte or
// cell word, the cell index and the two-byte size flag.
// Output stream (m_axis): one beat per accepted item, in order. tuser is the
// result kind; tdata carries cell address and value, cursor, attribute,
// scroll flag and escape-active flag.
// A two-entry command queue sits between the classifier and the executor, so
// input beats are taken while a result waits on a stalled receiver.
// An input beat is registered in a queue slot and then in the result register;
// reads also wait in S_RDWAIT for the registered RAM data. A byte that runs past
// the last cell scrolls by copying the screen memory one cell per cycle and
// blanking the last row. Outside scrolls, the executor takes the next command
// only after the result beat has left its output register.
// After reset the screen memory is cleared one cell per cycle; items are
// queued but not executed during the pass. A stalled receiver holds the
// result beat; the executor waits and the queue fills, then tready drops.
`timescale 1ns / 1ps
module text_console_sgr_writer import tcsw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // data[15:0], cell_index[26:16], size_is_two[27]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // cell_address[10:0], cell_value[26:11],
                                       // cursor_pos[37:27], attr_now[45:38],
                                       // scrolled[46], escape_active[47]
    output logic [1:0]  m_axis_tuser   // kind[1:0]
);
    t_cmd w_front_cmd, w_q_cmd;
    t_res w_res;
    logic w_full, w_q_valid, w_pop;

    tcsw_front u_front (
        .i_mode        (s_axis_tuser),
        .i_data        (s_axis_tdata[15:0]),
        .i_cell_index  (s_axis_tdata[26:16]),
        .i_size_is_two (s_axis_tdata[27]),
        .o_cmd         (w_front_cmd)
    );

    tcsw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    tcsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign s_axis_tready = !w_full;
    assign m_axis_tuser  = w_res.kind;
    assign m_axis_tdata  = {w_res.esc_active, w_res.scrolled, w_res.attr,
                            w_res.cursor, w_res.val, w_res.addr};
endmodule
